[hdl/pod_pkg.sv]
// ----------------------------------------------------------------------------
// pod_pkg
// Shared types and constants of the prefixed opcode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pod_pkg;

  localparam logic [7:0] HookLimitReset = 8'd7;

  localparam logic [7:0] PFX_CB  = 8'hcb;
  localparam logic [7:0] PFX_ED  = 8'hed;
  localparam logic [7:0] PFX_DD  = 8'hdd;
  localparam logic [7:0] PFX_FD  = 8'hfd;
  localparam logic [7:0] HOOK_OP = 8'hfe;
  localparam logic [7:0] HALT_OP = 8'h76;

  typedef enum logic [5:0] {
    CLS_NOP  = 6'd0,  CLS_LDRR = 6'd1,  CLS_LDRI = 6'd2,  CLS_ALU  = 6'd3,
    CLS_INR  = 6'd4,  CLS_DCR  = 6'd5,  CLS_LXI  = 6'd6,  CLS_DAD  = 6'd7,
    CLS_INX  = 6'd8,  CLS_DCX  = 6'd9,  CLS_LDAX = 6'd10, CLS_STAX = 6'd11,
    CLS_LDA  = 6'd12, CLS_STA  = 6'd13, CLS_LHLD = 6'd14, CLS_SHLD = 6'd15,
    CLS_ROT  = 6'd16, CLS_DAA  = 6'd17, CLS_CMA  = 6'd18, CLS_STC  = 6'd19,
    CLS_CMC  = 6'd20, CLS_JMP  = 6'd21, CLS_JCC  = 6'd22, CLS_CALL = 6'd23,
    CLS_CCC  = 6'd24, CLS_RET  = 6'd25, CLS_RCC  = 6'd26, CLS_RST  = 6'd27,
    CLS_PCHL = 6'd28, CLS_SPHL = 6'd29, CLS_XTHL = 6'd30, CLS_XCHG = 6'd31,
    CLS_PUSH = 6'd32, CLS_POP  = 6'd33, CLS_IN   = 6'd34, CLS_OUT  = 6'd35,
    CLS_EI   = 6'd36, CLS_DI   = 6'd37, CLS_HLT  = 6'd38, CLS_JR   = 6'd39,
    CLS_DJNZ = 6'd40, CLS_EXAF = 6'd41, CLS_EXX  = 6'd42, CLS_CB   = 6'd43,
    CLS_ED   = 6'd44, CLS_IX   = 6'd45, CLS_IXCB = 6'd46, CLS_HOOK = 6'd47,
    CLS_BAD  = 6'd48
  } pod_class_e;

  typedef struct packed {
    logic [15:0] fetch_pc;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
  } pod_item_t;

  typedef struct packed {
    pod_class_e         op_class;
    logic [2:0]         length;
    logic [7:0]         field_x;
    logic [2:0]         field_y;
    logic [7:0]         prefix_byte;
    logic [7:0]         sub_byte;
    logic [15:0]        immediate;
    logic signed [7:0]  displacement;
    logic               has_prefix;
    logic               has_immediate;
    logic               is_address;
    logic               uses_memory;
  } pod_result_t;

endpackage

`default_nettype wire

[hdl/pod_in_if.sv]
// ----------------------------------------------------------------------------
// pod_in_if
// Channel carrying one instruction window per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pod_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] fetch_pc;
  logic [7:0]  byte_0;
  logic [7:0]  byte_1;
  logic [7:0]  byte_2;
  logic [7:0]  byte_3;

  modport source (output valid, fetch_pc, byte_0, byte_1, byte_2, byte_3, input ready);
  modport sink   (input valid, fetch_pc, byte_0, byte_1, byte_2, byte_3, output ready);
endinterface

`default_nettype wire

[hdl/pod_out_if.sv]
// ----------------------------------------------------------------------------
// pod_out_if
// Channel carrying one decoded instruction per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pod_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        op_class;
  logic [2:0]        length;
  logic [7:0]        field_x;
  logic [2:0]        field_y;
  logic [7:0]        prefix_byte;
  logic [7:0]        sub_byte;
  logic [15:0]       immediate;
  logic signed [7:0] displacement;
  logic              has_prefix;
  logic              has_immediate;
  logic              is_address;
  logic              uses_memory;

  modport source (output valid, op_class, length, field_x, field_y, prefix_byte, sub_byte,
                  immediate, displacement, has_prefix, has_immediate, is_address,
                  uses_memory, input ready);
  modport sink   (input valid, op_class, length, field_x, field_y, prefix_byte, sub_byte,
                  immediate, displacement, has_prefix, has_immediate, is_address,
                  uses_memory, output ready);
endinterface

`default_nettype wire

[hdl/pod_cfg_if.sv]
// ----------------------------------------------------------------------------
// pod_cfg_if
// Write channel for the hook limit register.
// ----------------------------------------------------------------------------
`default_nettype none

interface pod_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] hook_limit;

  modport source (output valid, hook_limit, input ready);
  modport sink   (input valid, hook_limit, output ready);
endinterface

`default_nettype wire

[hdl/pod_cfg.sv]
// ----------------------------------------------------------------------------
// pod_cfg
// Hook limit register, written through its own channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pod_cfg
  import pod_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pod_cfg_if.sink    cfg_i,
  output logic [7:0] hook_limit_o
);

  logic [7:0] hook_limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hook_limit_q <= HookLimitReset;
    end else if (cfg_i.valid) begin
      hook_limit_q <= cfg_i.hook_limit;
    end
  end

  assign hook_limit_o = hook_limit_q;

endmodule

`default_nettype wire

[hdl/pod_stage.sv]
// ----------------------------------------------------------------------------
// pod_stage
// One register stage with valid and ready, able to pass a word every cycle while ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pod_stage #(
  parameter type T = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  wire T     data_i,
  output logic      ready_o,
  output logic      valid_o,
  output T          data_o,
  input  wire logic ready_i
);

  logic valid_q;
  T     data_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[hdl/pod_decode.sv]
// ----------------------------------------------------------------------------
// pod_decode
// Combinational decode of one instruction window into a result word.
// ----------------------------------------------------------------------------
`default_nettype none

module pod_decode
  import pod_pkg::*;
(
  input  wire pod_item_t  item_i,
  input  wire logic [7:0] hook_limit_i,
  output pod_result_t     result_o
);

  function automatic logic [2:0] plain_len(input logic [7:0] op);
    logic [2:0] len;
    len = 3'd1;
    if (op < 8'h40) begin
      if ((op & 8'hcf) == 8'h01 || op == 8'h22 || op == 8'h2a || op == 8'h32 ||
          op == 8'h3a) begin
        len = 3'd3;
      end else if (op[2:0] == 3'd6 || op == 8'h10 || op == 8'h18 || op == 8'h20 ||
                   op == 8'h28 || op == 8'h30 || op == 8'h38) begin
        len = 3'd2;
      end
    end else if (op >= 8'hc0) begin
      if (op[2:0] == 3'd2 || op[2:0] == 3'd4 || op == 8'hc3 || op == 8'hcd) begin
        len = 3'd3;
      end else if (op[2:0] == 3'd6 || op == 8'hd3 || op == 8'hdb) begin
        len = 3'd2;
      end
    end
    return len;
  endfunction

  function automatic logic hl_mem(input logic [7:0] op);
    logic m;
    m = 1'b0;
    if (op == 8'h34 || op == 8'h35 || op == 8'h36) begin
      m = 1'b1;
    end else if (op >= 8'h70 && op <= 8'h77) begin
      m = (op != HALT_OP);
    end else if (op >= 8'h40 && op <= 8'hbf) begin
      m = (op[2:0] == 3'd6);
    end
    return m;
  endfunction

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] w1;
  logic [15:0] rel;
  logic [2:0]  mid;
  logic [1:0]  pair;
  pod_result_t r;

  assign b0   = item_i.byte_0;
  assign b1   = item_i.byte_1;
  assign b2   = item_i.byte_2;
  assign b3   = item_i.byte_3;
  assign w1   = {b2, b1};
  assign rel  = item_i.fetch_pc + {{8{b1[7]}}, b1} + 16'd2;
  assign mid  = b0[5:3];
  assign pair = b0[5:4];

  always_comb begin
    r               = '0;
    r.op_class      = CLS_BAD;
    r.length        = plain_len(b0);
    if (b0 == PFX_CB) begin
      r.op_class    = CLS_CB;
      r.has_prefix  = 1'b1;
      r.prefix_byte = b0;
      r.sub_byte    = b1;
      r.field_x     = {6'd0, b1[7:6]};
      r.field_y     = b1[2:0];
      r.immediate   = {13'd0, b1[5:3]};
      r.uses_memory = (b1[2:0] == 3'd6);
      r.length      = 3'd2;
    end else if (b0 == PFX_ED) begin
      r.has_prefix  = 1'b1;
      r.prefix_byte = b0;
      r.sub_byte    = b1;
      if (b1 == HOOK_OP) begin
        r.field_x   = b2;
        r.length    = 3'd3;
        r.op_class  = (b2 > hook_limit_i) ? CLS_BAD : CLS_HOOK;
      end else begin
        r.op_class  = CLS_ED;
        r.length    = 3'd2;
        if ((b1 & 8'hc7) == 8'h43) begin
          r.length        = 3'd4;
          r.field_x       = {6'd0, b1[5:4]};
          r.immediate     = {b3, b2};
          r.has_immediate = 1'b1;
          r.is_address    = 1'b1;
          r.uses_memory   = 1'b1;
        end
      end
    end else if (b0 == PFX_DD || b0 == PFX_FD) begin
      r.has_prefix  = 1'b1;
      r.prefix_byte = b0;
      r.sub_byte    = b1;
      if (b1 == PFX_DD || b1 == PFX_FD || b1 == PFX_ED) begin
        r.op_class  = CLS_IX;
        r.length    = 3'd1;
      end else if (b1 == PFX_CB) begin
        r.op_class     = CLS_IXCB;
        r.displacement = b2;
        r.length       = 3'd4;
      end else begin
        r.op_class  = CLS_IX;
        r.length    = 3'd1 + plain_len(b1);
        if (hl_mem(b1)) begin
          r.length       = 3'd2 + plain_len(b1);
          r.displacement = b2;
        end
      end
    end else if (b0 >= 8'h40 && b0 <= 8'h7f) begin
      if (b0 == HALT_OP) begin
        r.op_class    = CLS_HLT;
      end else begin
        r.op_class    = CLS_LDRR;
        r.field_x     = {5'd0, mid};
        r.field_y     = b0[2:0];
        r.uses_memory = (mid == 3'd6) || (b0[2:0] == 3'd6);
      end
    end else if (b0 >= 8'h80 && b0 <= 8'hbf) begin
      r.op_class    = CLS_ALU;
      r.field_x     = {5'd0, mid};
      r.field_y     = b0[2:0];
      r.uses_memory = (b0[2:0] == 3'd6);
    end else if (b0 < 8'h40) begin
      unique case (b0[2:0])
        3'd0: begin
          if (b0 == 8'h00) begin
            r.op_class = CLS_NOP;
          end else if (b0 == 8'h08) begin
            r.op_class = CLS_EXAF;
          end else if (b0 == 8'h10) begin
            r.op_class  = CLS_DJNZ;
            r.immediate = rel;
          end else if (b0 == 8'h18) begin
            r.op_class  = CLS_JR;
            r.field_x   = 8'd4;
            r.immediate = rel;
          end else begin
            r.op_class  = CLS_JR;
            r.field_x   = {6'd0, mid[1:0]};
            r.immediate = rel;
          end
        end
        3'd1: begin
          r.field_x = {6'd0, pair};
          if (b0[3]) begin
            r.op_class = CLS_DAD;
          end else begin
            r.op_class      = CLS_LXI;
            r.immediate     = w1;
            r.has_immediate = 1'b1;
          end
        end
        3'd2: begin
          if (b0 < 8'h20) begin
            r.op_class    = b0[3] ? CLS_LDAX : CLS_STAX;
            r.field_x     = {7'd0, b0[4]};
            r.uses_memory = 1'b1;
          end else begin
            if (b0 == 8'h22) begin
              r.op_class = CLS_SHLD;
            end else if (b0 == 8'h2a) begin
              r.op_class = CLS_LHLD;
            end else if (b0 == 8'h32) begin
              r.op_class = CLS_STA;
            end else begin
              r.op_class = CLS_LDA;
            end
            r.immediate     = w1;
            r.has_immediate = 1'b1;
            r.is_address    = 1'b1;
            r.uses_memory   = 1'b1;
          end
        end
        3'd3: begin
          r.op_class = b0[3] ? CLS_DCX : CLS_INX;
          r.field_x  = {6'd0, pair};
        end
        3'd4: begin
          r.op_class    = CLS_INR;
          r.field_x     = {5'd0, mid};
          r.uses_memory = (mid == 3'd6);
        end
        3'd5: begin
          r.op_class    = CLS_DCR;
          r.field_x     = {5'd0, mid};
          r.uses_memory = (mid == 3'd6);
        end
        3'd6: begin
          r.op_class      = CLS_LDRI;
          r.field_x       = {5'd0, mid};
          r.immediate     = {8'd0, b1};
          r.has_immediate = 1'b1;
          r.uses_memory   = (mid == 3'd6);
        end
        default: begin
          if (b0 < 8'h20) begin
            r.op_class = CLS_ROT;
            r.field_x  = {6'd0, mid[1:0]};
          end else if (b0 == 8'h27) begin
            r.op_class = CLS_DAA;
          end else if (b0 == 8'h2f) begin
            r.op_class = CLS_CMA;
          end else if (b0 == 8'h37) begin
            r.op_class = CLS_STC;
          end else begin
            r.op_class = CLS_CMC;
          end
        end
      endcase
    end else begin
      unique case (b0[2:0])
        3'd0: begin
          r.op_class = CLS_RCC;
          r.field_x  = {5'd0, mid};
        end
        3'd1: begin
          if (b0[3]) begin
            if (b0 == 8'hc9) begin
              r.op_class = CLS_RET;
            end else if (b0 == 8'hd9) begin
              r.op_class = CLS_EXX;
            end else if (b0 == 8'he9) begin
              r.op_class = CLS_PCHL;
            end else begin
              r.op_class = CLS_SPHL;
            end
          end else begin
            r.op_class = CLS_POP;
            r.field_x  = {6'd0, pair};
          end
        end
        3'd2: begin
          r.op_class   = CLS_JCC;
          r.field_x    = {5'd0, mid};
          r.immediate  = w1;
          r.is_address = 1'b1;
        end
        3'd3: begin
          if (b0 == 8'hc3) begin
            r.op_class   = CLS_JMP;
            r.immediate  = w1;
            r.is_address = 1'b1;
          end else if (b0 == 8'hd3) begin
            r.op_class  = CLS_OUT;
            r.immediate = {8'd0, b1};
          end else if (b0 == 8'hdb) begin
            r.op_class  = CLS_IN;
            r.immediate = {8'd0, b1};
          end else if (b0 == 8'he3) begin
            r.op_class    = CLS_XTHL;
            r.uses_memory = 1'b1;
          end else if (b0 == 8'heb) begin
            r.op_class = CLS_XCHG;
          end else if (b0 == 8'hf3) begin
            r.op_class = CLS_DI;
          end else begin
            r.op_class = CLS_EI;
          end
        end
        3'd4: begin
          r.op_class   = CLS_CCC;
          r.field_x    = {5'd0, mid};
          r.immediate  = w1;
          r.is_address = 1'b1;
        end
        3'd5: begin
          if (b0 == 8'hcd) begin
            r.op_class   = CLS_CALL;
            r.immediate  = w1;
            r.is_address = 1'b1;
          end else begin
            r.op_class = CLS_PUSH;
            r.field_x  = {6'd0, pair};
          end
        end
        3'd6: begin
          r.op_class      = CLS_ALU;
          r.field_x       = {5'd0, mid};
          r.immediate     = {8'd0, b1};
          r.has_immediate = 1'b1;
        end
        default: begin
          r.op_class = CLS_RST;
          r.field_x  = {5'd0, mid};
        end
      endcase
    end
  end

  assign result_o = r;

endmodule

`default_nettype wire

[hdl/prefixed_opcode_decoder_top.sv]
// ----------------------------------------------------------------------------
// prefixed_opcode_decoder_top
// Decoder for prefixed 8080/Z80 instructions, one window per word.
// ----------------------------------------------------------------------------
// An upstream fetch unit presents a word on in_i: the fetch address and the
// four bytes found there. Each accepted word yields exactly one decoded word
// on out_o, in order. The hook limit is written through cfg_i, which is always
// ready; it should be changed only while no word is in flight.
//
// A word passes an input register, the decode logic and a result register,
// in that order. A new word is accepted every cycle while out_o.ready stays
// high; the single decode cone between the two registers sets that rate.
//
// When the receiver holds out_o.ready low the result register keeps its word
// and the input register fills behind it, after which in_i.ready drops. Reset
// empties both registers and sets the hook limit to seven.
// ----------------------------------------------------------------------------
`default_nettype none

module prefixed_opcode_decoder_top
  import pod_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pod_in_if.sink    in_i,
  pod_out_if.source out_o,
  pod_cfg_if.sink   cfg_i
);

  pod_item_t   item_in;
  pod_item_t   item_q;
  pod_result_t result_d;
  pod_result_t result_q;
  logic        item_valid;
  logic        item_ready;
  logic [7:0]  hook_limit;

  assign item_in = '{
    fetch_pc: in_i.fetch_pc,
    byte_0:   in_i.byte_0,
    byte_1:   in_i.byte_1,
    byte_2:   in_i.byte_2,
    byte_3:   in_i.byte_3
  };

  pod_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .hook_limit_o (hook_limit)
  );

  pod_stage #(.T(pod_item_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .data_i  (item_in),
    .ready_o (in_i.ready),
    .valid_o (item_valid),
    .data_o  (item_q),
    .ready_i (item_ready)
  );

  pod_decode u_decode (
    .item_i       (item_q),
    .hook_limit_i (hook_limit),
    .result_o     (result_d)
  );

  pod_stage #(.T(pod_result_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .data_i  (result_d),
    .ready_o (item_ready),
    .valid_o (out_o.valid),
    .data_o  (result_q),
    .ready_i (out_o.ready)
  );

  assign out_o.op_class      = result_q.op_class;
  assign out_o.length        = result_q.length;
  assign out_o.field_x       = result_q.field_x;
  assign out_o.field_y       = result_q.field_y;
  assign out_o.prefix_byte   = result_q.prefix_byte;
  assign out_o.sub_byte      = result_q.sub_byte;
  assign out_o.immediate     = result_q.immediate;
  assign out_o.displacement  = result_q.displacement;
  assign out_o.has_prefix    = result_q.has_prefix;
  assign out_o.has_immediate = result_q.has_immediate;
  assign out_o.is_address    = result_q.is_address;
  assign out_o.uses_memory   = result_q.uses_memory;

  a_accept_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> item_valid)
    else $error("Accepted word did not reach the input register.");

  a_length_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.length >= 3'd1 && out_o.length <= 3'd4)
    else $error("Decoded length out of range.");

  a_hook_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.op_class == CLS_HOOK |->
      out_o.has_prefix && out_o.length == 3'd3 && out_o.field_x <= hook_limit)
    else $error("Hook escape decoded with wrong form.");

  a_no_prefix_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.has_prefix |-> out_o.prefix_byte == 8'd0 &&
      out_o.sub_byte == 8'd0)
    else $error("Prefix fields set without a prefix.");

endmodule

`default_nettype wire

[verif/pod_decode_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pod_decode_checker
// Watches the decoder's channels, predicts each decoded word and compares.
// Every accepted instruction window is decoded here against the current
// hook limit and queued. Each accepted result word is compared field by field
// with the oldest queued decode. The mismatch count and the number of decodes
// still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module pod_decode_checker
  import pod_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  pod_in_if     in_mon,
  pod_out_if    out_mon,
  pod_cfg_if    cfg_mon,
  output int    words_pending,
  output int    mismatches
);

  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_EXAF   = 8'h08;
  localparam logic [7:0] OP_DJNZ   = 8'h10;
  localparam logic [7:0] OP_JR     = 8'h18;
  localparam logic [7:0] OP_JRNZ   = 8'h20;
  localparam logic [7:0] OP_JRZ    = 8'h28;
  localparam logic [7:0] OP_JRNC   = 8'h30;
  localparam logic [7:0] OP_JRC    = 8'h38;
  localparam logic [7:0] OP_SHLD   = 8'h22;
  localparam logic [7:0] OP_LHLD   = 8'h2a;
  localparam logic [7:0] OP_STA    = 8'h32;
  localparam logic [7:0] OP_LDA    = 8'h3a;
  localparam logic [7:0] OP_INR_M  = 8'h34;
  localparam logic [7:0] OP_DCR_M  = 8'h35;
  localparam logic [7:0] OP_MVI_M  = 8'h36;
  localparam logic [7:0] OP_DAA    = 8'h27;
  localparam logic [7:0] OP_CMA    = 8'h2f;
  localparam logic [7:0] OP_STC    = 8'h37;
  localparam logic [7:0] OP_RET    = 8'hc9;
  localparam logic [7:0] OP_EXX    = 8'hd9;
  localparam logic [7:0] OP_PCHL   = 8'he9;
  localparam logic [7:0] OP_JMP    = 8'hc3;
  localparam logic [7:0] OP_OUT    = 8'hd3;
  localparam logic [7:0] OP_IN     = 8'hdb;
  localparam logic [7:0] OP_XTHL   = 8'he3;
  localparam logic [7:0] OP_XCHG   = 8'heb;
  localparam logic [7:0] OP_DI     = 8'hf3;
  localparam logic [7:0] OP_CALL   = 8'hcd;
  localparam logic [7:0] ED_LD_MASK = 8'hc7;
  localparam logic [7:0] ED_LD_NN   = 8'h43;

  pod_result_t decodes_due [$];
  logic [7:0]  hook_limit;

  function automatic logic [2:0] opcode_length(input logic [7:0] op);
    if (op < 8'h40) begin
      if ((op & 8'hcf) == 8'h01) return 3'd3;
      if (op == OP_SHLD || op == OP_LHLD || op == OP_STA || op == OP_LDA) return 3'd3;
      if (op[2:0] == 3'd6) return 3'd2;
      if (op == OP_DJNZ || op == OP_JR || op == OP_JRNZ || op == OP_JRZ ||
          op == OP_JRNC || op == OP_JRC) return 3'd2;
      return 3'd1;
    end
    if (op < 8'hc0) return 3'd1;
    if (op[2:0] == 3'd2 || op[2:0] == 3'd4 || op == OP_JMP || op == OP_CALL) return 3'd3;
    if (op[2:0] == 3'd6 || op == OP_OUT || op == OP_IN) return 3'd2;
    return 3'd1;
  endfunction

  function automatic pod_result_t decode_window(input pod_item_t w, input logic [7:0] limit);
    pod_result_t r;
    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] word1, rel;
    logic [2:0]  mid;
    logic [1:0]  pair;
    logic        idx_mem;
    b0 = w.byte_0;
    b1 = w.byte_1;
    b2 = w.byte_2;
    b3 = w.byte_3;
    word1 = {b2, b1};
    rel = w.fetch_pc + {{8{b1[7]}}, b1} + 16'd2;
    mid = b0[5:3];
    pair = b0[5:4];
    r = '0;
    r.op_class = CLS_BAD;
    r.length = opcode_length(b0);
    if (b0 == PFX_CB) begin
      r.op_class = CLS_CB;
      r.has_prefix = 1'b1;
      r.prefix_byte = b0;
      r.sub_byte = b1;
      r.field_x = 8'(b1[7:6]);
      r.field_y = b1[2:0];
      r.immediate = 16'(b1[5:3]);
      r.uses_memory = (b1[2:0] == 3'd6);
      r.length = 3'd2;
    end else if (b0 == PFX_ED) begin
      r.has_prefix = 1'b1;
      r.prefix_byte = b0;
      r.sub_byte = b1;
      if (b1 == HOOK_OP) begin
        r.field_x = b2;
        r.length = 3'd3;
        r.op_class = (b2 > limit) ? CLS_BAD : CLS_HOOK;
      end else begin
        r.op_class = CLS_ED;
        r.length = 3'd2;
        if ((b1 & ED_LD_MASK) == ED_LD_NN) begin
          r.length = 3'd4;
          r.field_x = 8'(b1[5:4]);
          r.immediate = {b3, b2};
          r.has_immediate = 1'b1;
          r.is_address = 1'b1;
          r.uses_memory = 1'b1;
        end
      end
    end else if (b0 == PFX_DD || b0 == PFX_FD) begin
      r.has_prefix = 1'b1;
      r.prefix_byte = b0;
      r.sub_byte = b1;
      if (b1 == PFX_DD || b1 == PFX_FD || b1 == PFX_ED) begin
        r.op_class = CLS_IX;
        r.length = 3'd1;
      end else if (b1 == PFX_CB) begin
        r.op_class = CLS_IXCB;
        r.displacement = b2;
        r.length = 3'd4;
      end else begin
        if (b1 >= 8'h70 && b1 <= 8'h77) begin
          idx_mem = (b1 != HALT_OP);
        end else begin
          idx_mem = (b1 == OP_INR_M || b1 == OP_DCR_M || b1 == OP_MVI_M) ||
                    (b1 >= 8'h40 && b1 <= 8'hbf && b1[2:0] == 3'd6);
        end
        r.op_class = CLS_IX;
        r.length = 3'd1 + opcode_length(b1) + 3'(idx_mem);
        if (idx_mem) r.displacement = b2;
      end
    end else if (b0 >= 8'h40 && b0 <= 8'h7f) begin
      if (b0 == HALT_OP) begin
        r.op_class = CLS_HLT;
      end else begin
        r.op_class = CLS_LDRR;
        r.field_x = 8'(mid);
        r.field_y = b0[2:0];
        r.uses_memory = (mid == 3'd6 || b0[2:0] == 3'd6);
      end
    end else if (b0 >= 8'h80 && b0 <= 8'hbf) begin
      r.op_class = CLS_ALU;
      r.field_x = 8'(mid);
      r.field_y = b0[2:0];
      r.uses_memory = (b0[2:0] == 3'd6);
    end else if (b0 < 8'h40) begin
      case (b0[2:0])
        3'd0: begin
          if (b0 == OP_NOP) begin
            r.op_class = CLS_NOP;
          end else if (b0 == OP_EXAF) begin
            r.op_class = CLS_EXAF;
          end else if (b0 == OP_DJNZ) begin
            r.op_class = CLS_DJNZ;
            r.immediate = rel;
          end else if (b0 == OP_JR) begin
            r.op_class = CLS_JR;
            r.field_x = 8'd4;
            r.immediate = rel;
          end else begin
            r.op_class = CLS_JR;
            r.field_x = 8'(mid[1:0]);
            r.immediate = rel;
          end
        end
        3'd1: begin
          r.field_x = 8'(pair);
          if (b0[3]) begin
            r.op_class = CLS_DAD;
          end else begin
            r.op_class = CLS_LXI;
            r.immediate = word1;
            r.has_immediate = 1'b1;
          end
        end
        3'd2: begin
          if (b0 < 8'h20) begin
            r.op_class = b0[3] ? CLS_LDAX : CLS_STAX;
            r.field_x = 8'(b0[4]);
            r.uses_memory = 1'b1;
          end else begin
            if (b0 == OP_SHLD) r.op_class = CLS_SHLD;
            else if (b0 == OP_LHLD) r.op_class = CLS_LHLD;
            else if (b0 == OP_STA) r.op_class = CLS_STA;
            else r.op_class = CLS_LDA;
            r.immediate = word1;
            r.has_immediate = 1'b1;
            r.is_address = 1'b1;
            r.uses_memory = 1'b1;
          end
        end
        3'd3: begin
          r.op_class = b0[3] ? CLS_DCX : CLS_INX;
          r.field_x = 8'(pair);
        end
        3'd4, 3'd5: begin
          r.op_class = b0[0] ? CLS_DCR : CLS_INR;
          r.field_x = 8'(mid);
          r.uses_memory = (mid == 3'd6);
        end
        3'd6: begin
          r.op_class = CLS_LDRI;
          r.field_x = 8'(mid);
          r.immediate = 16'(b1);
          r.has_immediate = 1'b1;
          r.uses_memory = (mid == 3'd6);
        end
        default: begin
          if (b0 < 8'h20) begin
            r.op_class = CLS_ROT;
            r.field_x = 8'(mid[1:0]);
          end else if (b0 == OP_DAA) begin
            r.op_class = CLS_DAA;
          end else if (b0 == OP_CMA) begin
            r.op_class = CLS_CMA;
          end else if (b0 == OP_STC) begin
            r.op_class = CLS_STC;
          end else begin
            r.op_class = CLS_CMC;
          end
        end
      endcase
    end else begin
      case (b0[2:0])
        3'd0: begin
          r.op_class = CLS_RCC;
          r.field_x = 8'(mid);
        end
        3'd1: begin
          if (b0[3]) begin
            if (b0 == OP_RET) r.op_class = CLS_RET;
            else if (b0 == OP_EXX) r.op_class = CLS_EXX;
            else if (b0 == OP_PCHL) r.op_class = CLS_PCHL;
            else r.op_class = CLS_SPHL;
          end else begin
            r.op_class = CLS_POP;
            r.field_x = 8'(pair);
          end
        end
        3'd2, 3'd4: begin
          r.op_class = b0[2] ? CLS_CCC : CLS_JCC;
          r.field_x = 8'(mid);
          r.immediate = word1;
          r.is_address = 1'b1;
        end
        3'd3: begin
          if (b0 == OP_JMP) begin
            r.op_class = CLS_JMP;
            r.immediate = word1;
            r.is_address = 1'b1;
          end else if (b0 == OP_OUT) begin
            r.op_class = CLS_OUT;
            r.immediate = 16'(b1);
          end else if (b0 == OP_IN) begin
            r.op_class = CLS_IN;
            r.immediate = 16'(b1);
          end else if (b0 == OP_XTHL) begin
            r.op_class = CLS_XTHL;
            r.uses_memory = 1'b1;
          end else if (b0 == OP_XCHG) begin
            r.op_class = CLS_XCHG;
          end else if (b0 == OP_DI) begin
            r.op_class = CLS_DI;
          end else begin
            r.op_class = CLS_EI;
          end
        end
        3'd5: begin
          if (b0 == OP_CALL) begin
            r.op_class = CLS_CALL;
            r.immediate = word1;
            r.is_address = 1'b1;
          end else begin
            r.op_class = CLS_PUSH;
            r.field_x = 8'(pair);
          end
        end
        3'd6: begin
          r.op_class = CLS_ALU;
          r.field_x = 8'(mid);
          r.immediate = 16'(b1);
          r.has_immediate = 1'b1;
        end
        default: begin
          r.op_class = CLS_RST;
          r.field_x = 8'(mid);
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    pod_result_t want;
    pod_item_t   window;
    if (!rst_ni) begin
      hook_limit = HookLimitReset;
      decodes_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (decodes_due.size() == 0) begin
          $display("%0t: result word with no decode due, class %0d", $time,
                   out_mon.op_class);
          mismatches++;
        end else begin
          want = decodes_due.pop_front();
          check_field("op_class", int'(want.op_class), int'(out_mon.op_class));
          check_field("length", int'(want.length), int'(out_mon.length));
          check_field("field_x", int'(want.field_x), int'(out_mon.field_x));
          check_field("field_y", int'(want.field_y), int'(out_mon.field_y));
          check_field("prefix_byte", int'(want.prefix_byte), int'(out_mon.prefix_byte));
          check_field("sub_byte", int'(want.sub_byte), int'(out_mon.sub_byte));
          check_field("immediate", int'(want.immediate), int'(out_mon.immediate));
          check_field("displacement", int'(want.displacement), int'(out_mon.displacement));
          check_field("has_prefix", int'(want.has_prefix), int'(out_mon.has_prefix));
          check_field("has_immediate", int'(want.has_immediate),
                      int'(out_mon.has_immediate));
          check_field("is_address", int'(want.is_address), int'(out_mon.is_address));
          check_field("uses_memory", int'(want.uses_memory), int'(out_mon.uses_memory));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        window = {in_mon.fetch_pc, in_mon.byte_0, in_mon.byte_1, in_mon.byte_2,
                  in_mon.byte_3};
        decodes_due.push_back(decode_window(window, hook_limit));
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        hook_limit = cfg_mon.hook_limit;
      end
    end
    words_pending <= decodes_due.size();
  end

endmodule

[verif/prefixed_opcode_decoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefixed_opcode_decoder_top_tb
// Stimulus and verdict for the prefixed opcode decoder.
// A short directed set of instruction windows is followed by random windows
// weighted toward the CB, ED, hook and index prefixes, over several hook
// limit settings. Both channels idle and stall at random; the checker
// beside the block predicts and compares every decoded word.
// ----------------------------------------------------------------------------
module prefixed_opcode_decoder_top_tb
  import pod_pkg::*;
();

  localparam int RandomWords = 1800;
  localparam int PhaseCount  = 5;

  logic clk = 1'b0;
  logic rst_n;
  int   words_pending;
  int   mismatches;
  bit   tx_fast;

  pod_in_if  in_ch ();
  pod_out_if out_ch ();
  pod_cfg_if cfg_ch ();

  prefixed_opcode_decoder_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  pod_decode_checker decode_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .words_pending (words_pending),
    .mismatches    (mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_word(input logic [15:0] pc, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_fast = !tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.fetch_pc <= pc;
    in_ch.byte_0 <= b0;
    in_ch.byte_1 <= b1;
    in_ch.byte_2 <= b2;
    in_ch.byte_3 <= b3;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds off the sender until every decoded word has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] limit);
    cfg_ch.valid <= 1'b1;
    cfg_ch.hook_limit <= limit;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    bit rx_fast;
    rx_fast = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    logic [7:0]  limit;
    logic [15:0] pc;
    logic [7:0]  b0, b1, b2, b3;
    int          pick;
    tx_fast = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.fetch_pc <= '0;
    in_ch.byte_0 <= '0;
    in_ch.byte_1 <= '0;
    in_ch.byte_2 <= '0;
    in_ch.byte_3 <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.hook_limit <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    limit = HookLimitReset;

    send_word(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(16'hffff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_word(16'h1234, HALT_OP, 8'h5a, 8'ha5, 8'h3c);
    send_word(16'h0100, 8'h70, 8'h00, 8'h00, 8'h00);
    send_word(16'h0100, 8'h46, 8'h00, 8'h00, 8'h00);
    send_word(16'h0100, 8'hbe, 8'h00, 8'h00, 8'h00);
    send_word(16'h0100, 8'h01, 8'h34, 8'h12, 8'h00);
    send_word(16'h0100, 8'h22, 8'hcd, 8'hab, 8'h00);
    // Relative targets that wrap past either end of the address space.
    send_word(16'hfffe, 8'h10, 8'h80, 8'h00, 8'h00);
    send_word(16'hffff, 8'h18, 8'h7f, 8'h00, 8'h00);
    send_word(16'h0000, 8'h38, 8'hfe, 8'h00, 8'h00);
    send_word(16'h0200, PFX_CB, 8'h46, 8'h00, 8'h00);
    send_word(16'h0500, 8'hd3, 8'h20, 8'h00, 8'h00);
    send_word(16'h0300, PFX_ED, 8'h43, 8'h00, 8'h80);
    // Hook numbers at, just above and far above the limit.
    send_word(16'h0300, PFX_ED, HOOK_OP, 8'h07, 8'h00);
    send_word(16'h0300, PFX_ED, HOOK_OP, 8'h08, 8'h00);
    send_word(16'h0300, PFX_ED, HOOK_OP, 8'hff, 8'h00);
    // Repeated prefixes take length one.
    send_word(16'h0400, PFX_DD, PFX_DD, 8'h00, 8'h00);
    send_word(16'h0400, PFX_FD, PFX_ED, 8'h00, 8'h00);
    send_word(16'h0400, PFX_DD, PFX_CB, 8'h80, 8'h06);
    send_word(16'h0400, PFX_FD, 8'h36, 8'h7f, 8'h55);
    send_word(16'h0400, PFX_DD, HALT_OP, 8'h12, 8'h00);
    send_word(16'h0500, 8'hc3, 8'h00, 8'h80, 8'h00);
    send_word(16'h0500, 8'hcd, 8'hff, 8'hff, 8'h00);
    send_word(16'h0500, 8'hdb, 8'h10, 8'h00, 8'h00);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: limit = 8'h00;
          2: limit = 8'hff;
          3: limit = 8'($urandom_range(1, 254));
          default: limit = HookLimitReset;
        endcase
        write_limit(limit);
      end
      repeat (RandomWords / PhaseCount) begin
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 7) == 0) pc = 16'hff00 | 16'($urandom_range(0, 255));
        else pc = 16'($urandom);
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        if (pick >= 8 && pick < 10) begin
          b0 = PFX_CB;
        end else if (pick >= 10 && pick < 14) begin
          b0 = PFX_ED;
          if (pick < 12) begin
            b1 = HOOK_OP;
            if ($urandom_range(0, 1) == 1) b2 = limit + 8'($urandom_range(0, 2)) - 8'd1;
          end else if (pick == 12) begin
            b1 = {2'b01, b1[5:3], 3'b011};
          end
        end else if (pick >= 14 && pick < 19) begin
          b0 = ($urandom_range(0, 1) == 1) ? PFX_DD : PFX_FD;
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
              0: b1 = PFX_DD;
              1: b1 = PFX_FD;
              2: b1 = PFX_ED;
              default: b1 = PFX_CB;
            endcase
          end
        end
        send_word(pc, b0, b1, b2, b3);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
